// ===== hw/rtl/cihe_pkg.sv =====
// Package for the CBOR item head encoder: command codes, the queued command
// record, the back-end status record and shared constants. No dependencies.
`default_nettype none

package cihe_pkg;

  // Command codes carried by the func field.
  typedef enum logic [2:0] {
    FUNC_HEAD    = 3'd0,
    FUNC_SIGNED  = 3'd1,
    FUNC_RAW     = 3'd2,
    FUNC_DOUBLE  = 3'd3,
    FUNC_BOOL    = 3'd4,
    FUNC_NULL    = 3'd5,
    FUNC_RESTART = 3'd6
  } func_t;

  // CBOR additional-information markers and simple values.
  localparam logic [4:0] AI_ONE_BYTE   = 5'd24;
  localparam logic [4:0] AI_TWO_BYTE   = 5'd25;
  localparam logic [4:0] AI_FOUR_BYTE  = 5'd26;
  localparam logic [4:0] AI_EIGHT_BYTE = 5'd27;
  localparam logic [7:0] BYTE_DOUBLE   = 8'hfb;
  localparam logic [7:0] BYTE_TRUE     = 8'hf5;
  localparam logic [7:0] BYTE_FALSE    = 8'hf4;
  localparam logic [7:0] BYTE_NULL     = 8'hf6;
  localparam logic [2:0] MAJOR_NEG_INT = 3'd1;

  localparam logic [31:0] CAPACITY_RESET = 32'd4096;
  localparam logic [31:0] OFFSET_MAX     = 32'hffff_ffff;

  // Default depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified command: the head byte, how many argument bytes follow it,
  // and the argument left-aligned so the next byte is always in bits 63..56.
  typedef struct packed {
    logic        restart;
    logic [7:0]  head;
    logic [3:0]  nbytes;
    logic [63:0] val;
  } cmd_t;

  // Back-end serializer status, watched at the top level.
  typedef struct packed {
    logic       busy;
    logic [3:0] rem;
  } back_status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cihe_front.sv =====
// Front end of the CBOR item head encoder: accepts commands and classifies
// them into queue records (head byte, byte count, aligned argument). Uses cihe_pkg.
`default_nettype none

module cihe_front (
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [2:0]      in_func,
  input  wire logic [2:0]      in_major_type,
  input  wire logic [63:0]     in_argument,
  input  wire logic            q_full,
  output logic                 q_push,
  output cihe_pkg::cmd_t       q_cmd
);

  logic        is_head;
  logic [2:0]  major;
  logic [63:0] value;
  logic [7:0]  hd_byte;
  logic [3:0]  hd_n;
  logic [63:0] hd_val;
  logic        known;

  assign in_ready = !q_full;

  // Major type and argument for the head-shaped commands.
  always_comb begin
    major = in_major_type;
    value = in_argument;
    if (in_func == cihe_pkg::FUNC_SIGNED) begin
      if (in_argument[63]) begin
        major = cihe_pkg::MAJOR_NEG_INT;
        value = ~in_argument;
      end else begin
        major = 3'd0;
      end
    end
  end

  // Shortest head; the argument is left-aligned for the back end.
  always_comb begin
    if (value < 64'd24) begin
      hd_byte = {major, value[4:0]};
      hd_n    = 4'd0;
      hd_val  = '0;
    end else if (value[63:8] == '0) begin
      hd_byte = {major, cihe_pkg::AI_ONE_BYTE};
      hd_n    = 4'd1;
      hd_val  = {value[7:0], 56'd0};
    end else if (value[63:16] == '0) begin
      hd_byte = {major, cihe_pkg::AI_TWO_BYTE};
      hd_n    = 4'd2;
      hd_val  = {value[15:0], 48'd0};
    end else if (value[63:32] == '0) begin
      hd_byte = {major, cihe_pkg::AI_FOUR_BYTE};
      hd_n    = 4'd4;
      hd_val  = {value[31:0], 32'd0};
    end else begin
      hd_byte = {major, cihe_pkg::AI_EIGHT_BYTE};
      hd_n    = 4'd8;
      hd_val  = value;
    end
  end

  always_comb begin
    is_head       = 1'b0;
    known         = 1'b1;
    q_cmd.restart = 1'b0;
    q_cmd.head    = '0;
    q_cmd.nbytes  = '0;
    q_cmd.val     = '0;
    unique case (in_func) inside
      cihe_pkg::FUNC_HEAD,
      cihe_pkg::FUNC_SIGNED:  is_head = 1'b1;
      cihe_pkg::FUNC_RAW:     q_cmd.head = in_argument[7:0];
      cihe_pkg::FUNC_DOUBLE: begin
        q_cmd.head   = cihe_pkg::BYTE_DOUBLE;
        q_cmd.nbytes = 4'd8;
        q_cmd.val    = in_argument;
      end
      cihe_pkg::FUNC_BOOL:
        q_cmd.head = in_argument[0] ? cihe_pkg::BYTE_TRUE : cihe_pkg::BYTE_FALSE;
      cihe_pkg::FUNC_NULL:    q_cmd.head = cihe_pkg::BYTE_NULL;
      cihe_pkg::FUNC_RESTART: q_cmd.restart = 1'b1;
      default:                known = 1'b0;
    endcase
    if (is_head) begin
      q_cmd.head   = hd_byte;
      q_cmd.nbytes = hd_n;
      q_cmd.val    = hd_val;
    end
  end

  // The unused code is taken and dropped here without a queue entry.
  assign q_push = in_valid && !q_full && known;

endmodule

`default_nettype wire

// ===== hw/rtl/cihe_queue.sv =====
// Short command queue between the front and back of the CBOR head encoder.
// Flip-flop storage with read and write pointers. Uses cihe_pkg.
`default_nettype none

module cihe_queue #(
  parameter int unsigned DEPTH = cihe_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cihe_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output cihe_pkg::cmd_t      head_cmd,
  output logic                full,
  output logic                empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cihe_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           do_push, do_pop;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign head_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cihe_back.sv =====
// Back end of the CBOR head encoder: serializes queued commands into bytes,
// keeps offset, overflow and capacity, and drives the output register. Uses cihe_pkg.
`default_nettype none

module cihe_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           cfg_we,
  input  wire logic [31:0]    cfg_wdata,
  input  wire cihe_pkg::cmd_t q_cmd,
  input  wire logic           q_empty,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_byte,
  output logic [31:0]         out_byte_offset,
  output logic                out_dropped,
  output logic                out_overflow,
  output logic                out_last,
  output cihe_pkg::back_status_t status
);

  logic [31:0] capacity_r;
  logic [31:0] wl_r, wl_nxt;
  logic        ovf_r, ovf_nxt;
  logic        busy_r, busy_nxt;
  logic [3:0]  rem_r, rem_nxt;
  logic [63:0] val_r, val_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [31:0] off_r, off_nxt;
  logic        drop_r, drop_nxt;
  logic        oflag_r, oflag_nxt;
  logic        last_r, last_nxt;
  logic        load_ok, emit, drop;
  logic [7:0]  byte_sel;
  logic        last_sel;

  assign load_ok  = !out_valid_r || out_ready;
  assign q_pop    = !busy_r && load_ok && !q_empty;
  assign emit     = load_ok && (busy_r || (q_pop && !q_cmd.restart));
  assign byte_sel = busy_r ? val_r[63:56] : q_cmd.head;
  assign last_sel = busy_r ? (rem_r == 4'd1) : (q_cmd.nbytes == '0);
  assign drop     = (wl_r >= capacity_r);

  always_comb begin
    wl_nxt        = wl_r;
    ovf_nxt       = ovf_r;
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    val_nxt       = val_r;
    out_valid_nxt = out_valid_r;
    byte_nxt      = byte_r;
    off_nxt       = off_r;
    drop_nxt      = drop_r;
    oflag_nxt     = oflag_r;
    last_nxt      = last_r;
    if (load_ok) begin
      out_valid_nxt = emit;
    end
    if (q_pop && q_cmd.restart) begin
      wl_nxt  = '0;
      ovf_nxt = 1'b0;
    end
    if (emit) begin
      ovf_nxt   = ovf_r | drop;
      wl_nxt    = (wl_r == cihe_pkg::OFFSET_MAX) ? wl_r : wl_r + 32'd1;
      byte_nxt  = byte_sel;
      off_nxt   = wl_r;
      drop_nxt  = drop;
      oflag_nxt = ovf_r | drop;
      last_nxt  = last_sel;
      if (busy_r) begin
        val_nxt  = {val_r[55:0], 8'd0};
        rem_nxt  = rem_r - 4'd1;
        busy_nxt = (rem_r != 4'd1);
      end else begin
        val_nxt  = q_cmd.val;
        rem_nxt  = q_cmd.nbytes;
        busy_nxt = (q_cmd.nbytes != '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= cihe_pkg::CAPACITY_RESET;
      wl_r        <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      wl_r        <= wl_nxt;
      ovf_r       <= ovf_nxt;
      busy_r      <= busy_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r   <= val_nxt;
    byte_r  <= byte_nxt;
    off_r   <= off_nxt;
    drop_r  <= drop_nxt;
    oflag_r <= oflag_nxt;
    last_r  <= last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = byte_r;
  assign out_byte_offset = off_r;
  assign out_dropped     = drop_r;
  assign out_overflow    = oflag_r;
  assign out_last        = last_r;
  assign status.busy     = busy_r;
  assign status.rem      = rem_r;

endmodule

`default_nettype wire

// ===== hw/rtl/cbor_item_head_encoder_unit.sv =====
// Top level of the CBOR item head encoder (writer side).
// Instantiates cihe_front, cihe_queue and cihe_back; uses cihe_pkg.
`default_nettype none

// Each input transaction is one encoder command (head, signed integer, raw
// byte, double, boolean, null or restart) and yields zero to nine output
// transactions, one per encoded byte, each tagged with its buffer offset, a
// dropped bit for bytes at or beyond the programmed capacity, the sticky
// overflow flag and a last bit on the final byte of the command. The front
// end takes one command per clock into a short queue as long as the queue has
// room; the back end drains it and produces one byte per clock while the
// output is being taken. A head with n argument bytes yields n + 1 bytes
// (up to nine for an eight-byte argument or a double), and a restart yields
// no output; the serializer in the back end sets the byte rate. The unused
// command code is accepted and discarded in the front end. The capacity
// register (reset 4096) should only be written while the encoder is idle.

module cbor_item_head_encoder_unit #(
  parameter int unsigned QUEUE_DEPTH = cihe_pkg::QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [2:0]  in_major_type,
  input  wire logic [63:0] in_argument,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_byte,
  output logic [31:0]      out_byte_offset,
  output logic             out_dropped,
  output logic             out_overflow,
  output logic             out_last
);

  cihe_pkg::cmd_t         push_cmd;
  cihe_pkg::cmd_t         head_cmd;
  cihe_pkg::back_status_t bstat;
  logic                   q_push, q_pop, q_full, q_empty;

  // Front end: classifies each command into a head byte, a count of argument
  // bytes that follow it and a left-aligned argument word.
  cihe_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_major_type (in_major_type),
    .in_argument   (in_argument),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (push_cmd)
  );

  // Queue that lets the front keep accepting while the back serializes.
  cihe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  // Back end: offset and overflow tracking, byte serializer, output register.
  cihe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .q_cmd           (head_cmd),
    .q_empty         (q_empty),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_byte_offset (out_byte_offset),
    .out_dropped     (out_dropped),
    .out_overflow    (out_overflow),
    .out_last        (out_last),
    .status          (bstat)
  );

  // A dropped byte always carries the sticky overflow flag with it.
  a_drop_sets_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dropped |-> out_overflow)
    else $error("dropped byte without overflow flag");

  // While a non-final byte is presented, the rest of its command must still
  // be held in the serializer.
  a_not_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> bstat.busy)
    else $error("non-final byte with idle serializer");

  // The serializer is never busy with no bytes left to send.
  a_busy_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.busy |-> (bstat.rem != 4'd0))
    else $error("serializer busy with empty byte count");

  // No command is taken from the queue while the serializer is mid-command.
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.busy |-> !q_pop)
    else $error("queue popped during serialization");

endmodule

`default_nettype wire
